// ----- hw/rtl/pcw_pkg.sv -----
// ----------------------------------------------------------------------------
// pcw_pkg
// Shared types, codes and the BCH(31,21) syndrome function for the pager
// codeword encoder.
// ----------------------------------------------------------------------------
package pcw_pkg;

  localparam int unsigned CwDataBits  = 20;
  localparam int unsigned BchDataBits = 21;
  localparam int unsigned BchChkBits  = 10;

  // x^10 + x^9 + x^8 + x^6 + x^5 + x^3 + 1
  localparam logic [10:0] BCH_POLY  = 11'h769;
  localparam logic [6:0]  SHIFT_IN  = 7'h0F;
  localparam logic [6:0]  SHIFT_OUT = 7'h0E;

  typedef enum logic [1:0] {
    KIND_ADDR  = 2'd0,
    KIND_CHAR  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_e;

  typedef struct packed {
    logic       commit;
    logic [1:0] kind;
    logic [7:0] char_byte;
  } pack_step_t;

  typedef struct packed {
    logic                  done;
    logic [CwDataBits-1:0] data;
  } pack_res_t;

  // Remainder of x^(pos+10) mod g(x): check-bit contribution of data bit pos.
  function automatic logic [BchChkBits-1:0] bch_syndrome(int unsigned pos);
    logic [BchChkBits:0] r;
    r = (BchChkBits+1)'(1);
    for (int unsigned k = 0; k < pos + BchChkBits; k++) begin
      r = {r[BchChkBits-1:0], 1'b0};
      if (r[BchChkBits]) begin
        r = r ^ BCH_POLY;
      end
    end
    return r[BchChkBits-1:0];
  endfunction

endpackage

// ----- hw/rtl/pcw_in_if.sv -----
// ----------------------------------------------------------------------------
// pcw_in_if
// Input channel: one beat is an address, a message byte or a flush.
// ----------------------------------------------------------------------------
interface pcw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [20:0] pager_address;
  logic [1:0]  function_code;
  logic [7:0]  char_byte;

  modport source (output valid, kind, pager_address, function_code, char_byte,
                  input ready);
  modport sink   (input valid, kind, pager_address, function_code, char_byte,
                  output ready);
endinterface

// ----- hw/rtl/pcw_out_if.sv -----
// ----------------------------------------------------------------------------
// pcw_out_if
// Output channel: one beat is a finished 32-bit codeword.
// ----------------------------------------------------------------------------
interface pcw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] codeword;
  logic        is_address;

  modport source (output valid, codeword, is_address, input ready);
  modport sink   (input valid, codeword, is_address, output ready);
endinterface

// ----- hw/rtl/pcw_bch.sv -----
// ----------------------------------------------------------------------------
// pcw_bch
// Appends the ten BCH(31,21) check bits and the even parity bit to 21 bits
// of codeword data.
// ----------------------------------------------------------------------------
module pcw_bch (
  input  logic [20:0] data_i,
  output logic [31:0] codeword_o
);
  import pcw_pkg::*;

  logic [BchChkBits-1:0] term [BchDataBits];
  logic [BchChkBits-1:0] check;

  for (genvar g = 0; g < BchDataBits; g++) begin : g_syn
    localparam logic [BchChkBits-1:0] Syn = bch_syndrome(g);
    assign term[g] = data_i[g] ? Syn : '0;
  end

  always_comb begin
    check = '0;
    for (int i = 0; i < BchDataBits; i++) begin
      check = check ^ term[i];
    end
  end

  assign codeword_o = {data_i, check, ^{data_i, check}};

endmodule

// ----- hw/rtl/pcw_msg_pack.sv -----
// ----------------------------------------------------------------------------
// pcw_msg_pack
// Message bit packer: inserts shift-in/shift-out, packs 7-bit characters
// LSB first into 20-bit codeword payloads and handles flush.
// ----------------------------------------------------------------------------
module pcw_msg_pack (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcw_pkg::pack_step_t step_i,
  output pcw_pkg::pack_res_t  res_o
);
  import pcw_pkg::*;

  localparam int unsigned WideBits = CwDataBits + 14;

  logic [CwDataBits-1:0] acc_q, acc_d;
  logic [4:0]            cnt_q, cnt_d;
  logic                  last_high_q, last_high_d;

  logic                high, need_pfx;
  logic [6:0]          pfx;
  logic [13:0]         stream;
  logic [WideBits-1:0] wide;
  logic [5:0]          total, over_bits;
  logic                over;

  function automatic logic [6:0] rev7(logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) begin
      r[i] = v[6-i];
    end
    return r;
  endfunction

  always_comb begin
    high     = step_i.char_byte[7];
    need_pfx = high ? !last_high_q : last_high_q;
    pfx      = high ? SHIFT_OUT : SHIFT_IN;
    // First bit sent sits highest, so each character is bit-reversed.
    if (need_pfx) begin
      stream = {rev7(pfx), rev7(step_i.char_byte[6:0])};
      wide   = ({14'b0, acc_q} << 14) | {20'b0, stream};
      total  = {1'b0, cnt_q} + 6'd14;
    end else begin
      stream = {7'b0, rev7(step_i.char_byte[6:0])};
      wide   = ({14'b0, acc_q} << 7) | {20'b0, stream};
      total  = {1'b0, cnt_q} + 6'd7;
    end
    over      = total >= 6'(CwDataBits);
    over_bits = total - 6'(CwDataBits);

    res_o       = '0;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    last_high_d = last_high_q;
    case (kind_e'(step_i.kind))
      KIND_CHAR: begin
        last_high_d = high;
        if (over) begin
          res_o.done = 1'b1;
          res_o.data = CwDataBits'(wide >> over_bits);
          acc_d      = CwDataBits'(wide & ((WideBits'(1) << over_bits) - WideBits'(1)));
          cnt_d      = over_bits[4:0];
        end else begin
          acc_d = CwDataBits'(wide);
          cnt_d = total[4:0];
        end
      end
      KIND_FLUSH: begin
        // Pad the partial payload with zeros at the tail.
        res_o.done  = cnt_q != 5'd0;
        res_o.data  = acc_q << (5'(CwDataBits) - cnt_q);
        acc_d       = '0;
        cnt_d       = '0;
        last_high_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      last_high_q <= 1'b1;
    end else if (step_i.commit) begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      last_high_q <= last_high_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < 5'(CwDataBits))
    else $error("pending bit count out of range");

  a_acc_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q >> cnt_q) == '0)
    else $error("accumulator holds bits beyond the pending count");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i.commit && (step_i.kind == KIND_FLUSH)
    |=> (cnt_q == 5'd0) && (acc_q == '0) && last_high_q)
    else $error("flush did not clear the message state");

endmodule

// ----- hw/rtl/pocsag_codeword_encoder.sv -----
// ----------------------------------------------------------------------------
// pocsag_codeword_encoder
// Pager codeword encoder: address codewords and packed message codewords
// with BCH(31,21) check bits and even parity.
// ----------------------------------------------------------------------------
//  Channel | Dir | Beat contents
//  --------+-----+-----------------------------------------------------
//  in_i    | in  | kind, pager_address, function_code, char_byte
//  out_o   | out | codeword, is_address (zero or one beat per input beat)
//
//  One input beat per cycle while the output is not stalled; a result passes
//  through the input register, then through the packer and the BCH network
//  into the output register.
//  Reset clears the message state (no pending bits, a leading 7-bit byte
//  gets shift-in, a leading high byte gets no shift-out).
//  A stalled output holds the pipe; input is still taken while the input
//  register is empty or the output register moves on.
// ----------------------------------------------------------------------------
module pocsag_codeword_encoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  pcw_in_if.sink    in_i,
  pcw_out_if.source out_o
);
  import pcw_pkg::*;

  logic        in_vld_q;
  logic [1:0]  kind_q;
  logic [20:0] addr_q;
  logic [1:0]  fn_q;
  logic [7:0]  byte_q;

  logic        out_vld_q, out_vld_d;
  logic [31:0] cw_q, cw_d;
  logic        is_addr_q, is_addr_d;

  logic        adv;
  logic        in_fire;
  logic        is_addr;
  logic [20:0] bch_data;
  pack_step_t  step;
  pack_res_t   pack_res;

  assign adv        = !out_vld_q || out_o.ready;
  assign in_i.ready = !in_vld_q || adv;
  assign in_fire    = in_i.valid && in_i.ready;

  assign step.commit    = in_vld_q && adv;
  assign step.kind      = kind_q;
  assign step.char_byte = byte_q;

  pcw_msg_pack u_pack (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (pack_res)
  );

  assign is_addr  = kind_q == KIND_ADDR;
  assign bch_data = is_addr ? {1'b0, addr_q[20:3], fn_q} : {1'b1, pack_res.data};

  pcw_bch u_bch (
    .data_i     (bch_data),
    .codeword_o (cw_d)
  );

  assign out_vld_d = in_vld_q && (is_addr || pack_res.done);
  assign is_addr_d = is_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (adv) begin
        out_vld_q <= out_vld_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= in_i.kind;
      addr_q <= in_i.pager_address;
      fn_q   <= in_i.function_code;
      byte_q <= in_i.char_byte;
    end
    if (adv) begin
      cw_q      <= cw_d;
      is_addr_q <= is_addr_d;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.codeword   = cw_q;
  assign out_o.is_address = is_addr_q;

  a_flag_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (cw_q[31] != is_addr_q))
    else $error("codeword flag bit disagrees with codeword type");

  a_even_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (^cw_q == 1'b0))
    else $error("codeword parity is odd");

  a_addr_always_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.commit && is_addr |=> out_vld_q && is_addr_q)
    else $error("address beat produced no codeword");

endmodule

// ----- tb/sv/pocsag_codeword_checker.sv -----
// ----------------------------------------------------------------------------
// pocsag_codeword_checker
// Watches both channels of the pager codeword encoder. Every accepted input
// beat updates a local copy of the message packer and queues the codeword it
// completes; every accepted output beat is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module pocsag_codeword_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcw_in_if           in_mon_i,
  pcw_out_if          out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import pcw_pkg::*;

  localparam logic [31:0] GenWord = {BCH_POLY, 21'd0};
  localparam int unsigned ReportMax = 10;

  typedef struct packed {
    logic [31:0] codeword;
    logic        is_address;
  } cw_beat_t;

  cw_beat_t    cw_expect_q[$];
  logic [19:0] msg_bits;
  logic [4:0]  msg_fill;
  logic        prev_high;
  int unsigned fails;

  // Append BCH(31,21) check bits in 10..1 and even parity in bit 0.
  function automatic logic [31:0] seal_word(logic [31:0] raw);
    logic [31:0] rem;
    logic [31:0] cw;
    rem = raw;
    cw  = raw;
    for (int i = 0; i < 21; i++) begin
      if (rem[31]) begin
        rem = rem ^ GenWord;
      end
      rem = rem << 1;
    end
    cw[10:1] = cw[10:1] | rem[31:22];
    cw[0]    = cw[0] | (^cw[31:1]);
    return cw;
  endfunction

  function automatic void queue_message(logic [19:0] data);
    cw_beat_t b;
    b.codeword   = seal_word({1'b1, data, 11'd0});
    b.is_address = 1'b0;
    cw_expect_q.push_back(b);
  endfunction

  // Shift in seven character bits, LSB first; emit a codeword every 20 bits.
  function automatic void pack_char(logic [6:0] ch);
    for (int j = 0; j < 7; j++) begin
      msg_bits = {msg_bits[18:0], ch[j]};
      msg_fill = msg_fill + 5'd1;
      if (msg_fill == 5'd20) begin
        queue_message(msg_bits);
        msg_bits = '0;
        msg_fill = '0;
      end
    end
  endfunction

  function automatic void predict_beat(logic [1:0] kind, logic [20:0] addr,
                                       logic [1:0] fn, logic [7:0] chr);
    cw_beat_t b;
    case (kind)
      KIND_ADDR: begin
        b.codeword   = seal_word({1'b0, addr[20:3], fn, 11'd0});
        b.is_address = 1'b1;
        cw_expect_q.push_back(b);
      end
      KIND_CHAR: begin
        if (!chr[7] && prev_high) begin
          pack_char(SHIFT_IN);
        end
        if (chr[7] && !prev_high) begin
          pack_char(SHIFT_OUT);
        end
        pack_char(chr[6:0]);
        prev_high = chr[7];
      end
      KIND_FLUSH: begin
        if (msg_fill != 5'd0) begin
          queue_message(msg_bits << (5'd20 - msg_fill));
        end
        msg_bits  = '0;
        msg_fill  = '0;
        prev_high = 1'b1;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cw_beat_t want;
    if (!rst_ni) begin
      msg_bits  = '0;
      msg_fill  = '0;
      prev_high = 1'b1;
      fails     = 0;
      cw_expect_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // compare first: a beat leaving now never belongs to the beat entering
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (cw_expect_q.size() == 0) begin
          fails++;
          if (fails <= ReportMax) begin
            $display("unexpected codeword beat: %h is_address %b",
                     out_mon_i.codeword, out_mon_i.is_address);
          end
        end else begin
          want = cw_expect_q.pop_front();
          if (out_mon_i.codeword !== want.codeword ||
              out_mon_i.is_address !== want.is_address) begin
            fails++;
            if (fails <= ReportMax) begin
              $display("codeword beat differs: expected %h/%b, got %h/%b",
                       want.codeword, want.is_address,
                       out_mon_i.codeword, out_mon_i.is_address);
            end
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        predict_beat(in_mon_i.kind, in_mon_i.pager_address,
                     in_mon_i.function_code, in_mon_i.char_byte);
      end
      fail_count_o <= fails;
      pending_o    <= cw_expect_q.size();
    end
  end

endmodule

// ----- tb/sv/pocsag_codeword_encoder_test.sv -----
// ----------------------------------------------------------------------------
// pocsag_codeword_encoder_test
// Drives address, message byte and flush beats into the pager codeword
// encoder with random gaps and output stalls; the checker beside the block
// predicts and compares every codeword.
// ----------------------------------------------------------------------------
module pocsag_codeword_encoder_test;
  import pcw_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int unsigned ItemTarget = 1400;
  localparam int unsigned LongHold = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned item_count;
  bit          send_calm;
  bit          recv_calm;

  pcw_in_if  in_ch ();
  pcw_out_if out_ch ();

  pocsag_codeword_encoder u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pocsag_codeword_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_ch),
    .out_mon_i    (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int unsigned pick_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // Present one beat and hold it until taken; valid stays high into the next
  // beat when no gap is drawn.
  task automatic send_beat(logic [1:0] kind, logic [20:0] addr, logic [1:0] fn,
                           logic [7:0] chr);
    int unsigned gap;
    if ($urandom_range(0, 59) == 0) begin
      send_calm = !send_calm;
    end
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.pager_address <= addr;
    in_ch.function_code <= fn;
    in_ch.char_byte     <= chr;
    do @(posedge clk_i); while (!in_ch.ready);
    if (kind != KindUnused) begin
      item_count++;
    end
  endtask

  task automatic send_char(logic [7:0] chr);
    send_beat(KIND_CHAR, 21'($urandom), 2'($urandom), chr);
  endtask

  task automatic send_addr(logic [20:0] addr, logic [1:0] fn);
    send_beat(KIND_ADDR, addr, fn, 8'($urandom));
  endtask

  task automatic send_flush();
    send_beat(KIND_FLUSH, 21'($urandom), 2'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    send_beat(2'($urandom), 21'($urandom), 2'($urandom), 8'($urandom));
  endtask

  initial begin
    int unsigned len;
    bit          run_high;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.kind          = KIND_ADDR;
    in_ch.pager_address = '0;
    in_ch.function_code = '0;
    in_ch.char_byte     = '0;
    item_count          = 0;
    send_calm           = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // address extremes and alternating patterns
    send_addr(21'h000000, 2'd0);
    send_addr(21'h1FFFFF, 2'd3);
    send_addr(21'h0AAAAA, 2'd1);
    send_addr(21'h155555, 2'd2);
    send_flush();                        // nothing pending: no codeword
    send_noise();
    send_beat(KindUnused, 21'h1FFFFF, 2'd3, 8'hFF);
    send_char(8'h80);                    // high byte opens message: no shift-out
    send_char(8'hFF);
    send_char(8'h00);                    // low after high: shift-in
    send_char(8'h7F);
    send_addr(21'($urandom), 2'($urandom)); // address mid-message
    send_char(8'hC1);                    // high after low: shift-out
    send_beat(KindUnused, 21'h0, 2'd0, 8'h00);
    send_char(8'h41);
    send_flush();                        // pad partial codeword
    send_flush();
    send_char(8'h20);                    // low byte opens message: shift-in
    send_char(8'h55);
    send_flush();

    while (item_count < ItemTarget) begin
      if ($urandom_range(0, 9) < 8) begin
        send_addr(21'($urandom), 2'($urandom));
        len      = $urandom_range(1, 30);
        run_high = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            run_high = !run_high;
          end
          if ($urandom_range(0, 19) == 0) begin
            send_addr(21'($urandom), 2'($urandom));
          end
          send_char({run_high, 7'($urandom)});
        end
        if ($urandom_range(0, 5) != 0) begin
          send_flush();
        end
      end else begin
        repeat ($urandom_range(1, 6)) send_noise();
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("pocsag_codeword_encoder: match");
    end else begin
      $display("pocsag_codeword_encoder: mismatch");
    end
    $finish;
  end

  // Receiver: random stalls, calm stretches and two long hold-offs.
  initial begin
    int unsigned taken;
    int unsigned hold;
    out_ch.ready = 1'b0;
    taken        = 0;
    recv_calm    = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 59) == 0) begin
        recv_calm = !recv_calm;
      end
      if (taken == 25 || taken == 400) begin
        hold = LongHold;
      end else begin
        hold = pick_gap(recv_calm);
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      taken++;
    end
  end

  initial begin
    #5000000;
    $display("pocsag_codeword_encoder: mismatch");
    $finish;
  end

endmodule
